// ===== hw/rtl/drh_pkg.sv =====
package drh_pkg;

  // Store geometry. Position zero of every store is a constant and is not held in memory.
  localparam int MAX_LEN = 4096;
  localparam int POS_W   = $clog2(MAX_LEN + 1);
  localparam int ADDR_W  = $clog2(MAX_LEN);

  // Arithmetic widths.
  localparam int WORD_W = 31;
  localparam int PROD_W = 2 * WORD_W;
  localparam int DIVD_W = PROD_W + 1;
  localparam int HASH_W = 63;
  localparam int CHAR_W = 8;
  localparam int CNT_W  = $clog2(DIVD_W);

  // Register reset values.
  localparam logic [WORD_W-1:0] BASE_LEFT_RST     = WORD_W'(131);
  localparam logic [WORD_W-1:0] BASE_RIGHT_RST    = WORD_W'(137);
  localparam logic [WORD_W-1:0] MODULUS_LEFT_RST  = WORD_W'(1000000007);
  localparam logic [WORD_W-1:0] MODULUS_RIGHT_RST = WORD_W'(998244353);

  typedef enum logic [1:0] {
    REG_BASE_LEFT     = 2'd0,
    REG_BASE_RIGHT    = 2'd1,
    REG_MODULUS_LEFT  = 2'd2,
    REG_MODULUS_RIGHT = 2'd3
  } cfg_reg_t;

  typedef enum logic [1:0] {
    FN_APPEND = 2'd0,
    FN_QUERY  = 2'd1,
    FN_CLEAR  = 2'd2
  } func_t;

  typedef enum logic [1:0] {
    STAT_OK        = 2'd0,
    STAT_BAD_RANGE = 2'd1,
    STAT_FULL      = 2'd2
  } status_t;

  typedef enum logic [3:0] {
    SQ_IDLE,
    SQ_A_RD,
    SQ_A_MUL1,
    SQ_A_RED1,
    SQ_A_MUL2,
    SQ_A_RED2,
    SQ_Q_RD,
    SQ_Q_MUL,
    SQ_Q_RED1,
    SQ_Q_LDA,
    SQ_Q_RED2,
    SQ_DONE
  } seq_state_t;

  // Operand source for the reduction unit's dividend.
  typedef enum logic [1:0] {
    SRC_PFX_BASE,
    SRC_POW_BASE,
    SRC_PFX_POW,
    SRC_PFX
  } src_t;

  // Control from the sequencer to each hash lane.
  typedef struct packed {
    logic             rd_pfx;
    logic [POS_W-1:0] pfx_pos;
    logic             rd_pow;
    logic [POS_W-1:0] pow_pos;
    logic             wr_pfx;
    logic             wr_pow;
    logic [POS_W-1:0] wr_pos;
    logic             start;
    src_t             src;
    logic [CHAR_W-1:0] ch;
    logic             take_x;
    logic             take_hash;
  } lane_ctl_t;

endpackage

// ===== hw/rtl/drh_ram.sv =====
module drh_ram #(
  parameter int DEPTH = 4096,
  parameter int WIDTH = 31
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // One write port; read data is registered and holds until the next read.
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// ===== hw/rtl/drh_mod_unit.sv =====
module drh_mod_unit (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         start,
  input  logic [drh_pkg::DIVD_W-1:0]   dividend,
  input  logic [drh_pkg::WORD_W-1:0]   modulus,
  output logic                         busy,
  output logic                         done,
  output logic [drh_pkg::WORD_W-1:0]   remainder
);

  localparam logic [drh_pkg::CNT_W-1:0] LAST_STEP = drh_pkg::CNT_W'(drh_pkg::DIVD_W - 1);

  logic [drh_pkg::DIVD_W-1:0] divd;
  logic [drh_pkg::CNT_W-1:0]  cnt;
  logic [drh_pkg::WORD_W:0]   shifted;
  logic [drh_pkg::WORD_W:0]   mod_ext;
  logic [drh_pkg::WORD_W-1:0] rem_next;

  // One restoring step: bring in the next dividend bit, subtract the modulus if it fits.
  always_comb begin
    shifted = {remainder, divd[drh_pkg::DIVD_W-1]};
    mod_ext = {1'b0, modulus};
    if (shifted >= mod_ext) begin
      rem_next = drh_pkg::WORD_W'(shifted - mod_ext);
    end else begin
      rem_next = shifted[drh_pkg::WORD_W-1:0];
    end
  end

  // Step counter and completion pulse.
  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt  <= '0;
      end else if (busy) begin
        cnt <= cnt + 1'b1;
        if (cnt == LAST_STEP) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  // Dividend shift register and partial remainder.
  always_ff @(posedge clk) begin
    if (start) begin
      divd      <= dividend;
      remainder <= '0;
    end else if (busy) begin
      divd      <= divd << 1;
      remainder <= rem_next;
    end
  end

`ifndef ASSERT_OFF
  a_start_idle: assert property (@(posedge clk) disable iff (rst) start |-> !busy)
    else $error("reduction started while a reduction is running");
  a_done_pulse: assert property (@(posedge clk) disable iff (rst) done |=> !done)
    else $error("reduction done held for more than one cycle");
  a_rem_below_mod: assert property (@(posedge clk) disable iff (rst)
    done |-> remainder < modulus)
    else $error("remainder not reduced below the modulus");
`endif

endmodule

// ===== hw/rtl/drh_lane.sv =====
module drh_lane (
  input  logic                       clk,
  input  logic                       rst,
  input  drh_pkg::lane_ctl_t         ctl,
  input  logic [drh_pkg::WORD_W-1:0] base,
  input  logic [drh_pkg::WORD_W-1:0] modulus,
  output logic                       done,
  output logic [drh_pkg::WORD_W-1:0] hash
);

  logic [drh_pkg::WORD_W-1:0] m_eff;
  logic [drh_pkg::WORD_W-1:0] pfx_rdata;
  logic [drh_pkg::WORD_W-1:0] pow_rdata;
  logic [drh_pkg::WORD_W-1:0] pfx_val;
  logic [drh_pkg::WORD_W-1:0] pow_val;
  logic                       pfx_zero;
  logic                       pow_zero;
  logic [drh_pkg::ADDR_W-1:0] pfx_raddr;
  logic [drh_pkg::ADDR_W-1:0] pow_raddr;
  logic [drh_pkg::ADDR_W-1:0] waddr;
  logic [drh_pkg::WORD_W-1:0] mul_a;
  logic [drh_pkg::WORD_W-1:0] mul_b;
  logic [drh_pkg::PROD_W-1:0] prod;
  logic [drh_pkg::DIVD_W-1:0] dividend;
  logic                       busy;
  logic [drh_pkg::WORD_W-1:0] rem;
  logic [drh_pkg::WORD_W-1:0] x_hold;
  logic [drh_pkg::WORD_W:0]   diff;

  // A modulus of zero acts as one.
  assign m_eff = (modulus == '0) ? drh_pkg::WORD_W'(1) : modulus;

  // Position p lives at memory address p - 1.
  assign pfx_raddr = drh_pkg::ADDR_W'(ctl.pfx_pos - 1'b1);
  assign pow_raddr = drh_pkg::ADDR_W'(ctl.pow_pos - 1'b1);
  assign waddr     = drh_pkg::ADDR_W'(ctl.wr_pos - 1'b1);

  drh_ram #(
    .DEPTH(drh_pkg::MAX_LEN),
    .WIDTH(drh_pkg::WORD_W)
  ) u_pfx_ram (
    .clk  (clk),
    .we   (ctl.wr_pfx),
    .waddr(waddr),
    .wdata(rem),
    .re   (ctl.rd_pfx),
    .raddr(pfx_raddr),
    .rdata(pfx_rdata)
  );

  drh_ram #(
    .DEPTH(drh_pkg::MAX_LEN),
    .WIDTH(drh_pkg::WORD_W)
  ) u_pow_ram (
    .clk  (clk),
    .we   (ctl.wr_pow),
    .waddr(waddr),
    .wdata(rem),
    .re   (ctl.rd_pow),
    .raddr(pow_raddr),
    .rdata(pow_rdata)
  );

  // Track reads of position zero, whose entries are fixed constants.
  always_ff @(posedge clk) begin
    if (ctl.rd_pfx) begin
      pfx_zero <= (ctl.pfx_pos == '0);
    end
    if (ctl.rd_pow) begin
      pow_zero <= (ctl.pow_pos == '0);
    end
  end

  assign pfx_val = pfx_zero ? '0 : pfx_rdata;
  assign pow_val = pow_zero ? drh_pkg::WORD_W'(1) : pow_rdata;

  // Single multiplier feeding the reduction unit's dividend register.
  always_comb begin
    mul_a = pfx_val;
    mul_b = base;
    case (ctl.src)
      drh_pkg::SRC_POW_BASE: mul_a = pow_val;
      drh_pkg::SRC_PFX_POW:  mul_b = pow_val;
      default: ;
    endcase
    prod = drh_pkg::PROD_W'(mul_a) * drh_pkg::PROD_W'(mul_b);
    case (ctl.src)
      drh_pkg::SRC_PFX_BASE: dividend = {1'b0, prod} + drh_pkg::DIVD_W'(ctl.ch);
      drh_pkg::SRC_PFX:      dividend = drh_pkg::DIVD_W'(pfx_val);
      default:               dividend = {1'b0, prod};
    endcase
  end

  drh_mod_unit u_mod (
    .clk      (clk),
    .rst      (rst),
    .start    (ctl.start),
    .dividend (dividend),
    .modulus  (m_eff),
    .busy     (busy),
    .done     (done),
    .remainder(rem)
  );

  // Final step of a query: (a - x) mod m with both terms already reduced.
  always_comb begin
    if (rem >= x_hold) begin
      diff = {1'b0, drh_pkg::WORD_W'(rem - x_hold)};
    end else begin
      diff = {1'b0, rem} + {1'b0, m_eff} - {1'b0, x_hold};
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.take_x) begin
      x_hold <= rem;
    end
    if (ctl.take_hash) begin
      hash <= diff[drh_pkg::WORD_W-1:0];
    end
  end

`ifndef ASSERT_OFF
  a_no_write_busy: assert property (@(posedge clk) disable iff (rst)
    (ctl.wr_pfx || ctl.wr_pow) |-> (done && !busy))
    else $error("store written before the reduction finished");
`endif

endmodule

// ===== hw/rtl/drh_seq.sv =====
module drh_seq (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        in_valid,
  output logic                        in_stall,
  input  logic [1:0]                  func,
  input  logic [drh_pkg::CHAR_W-1:0]  char_byte,
  input  logic [drh_pkg::POS_W-1:0]   begin_pos,
  input  logic [drh_pkg::POS_W-1:0]   end_pos,
  output logic                        out_valid,
  input  logic                        out_stall,
  output logic [1:0]                  status,
  output logic [drh_pkg::HASH_W-1:0]  hash_value,
  output logic [drh_pkg::POS_W-1:0]   string_size,
  output drh_pkg::lane_ctl_t          ctl,
  input  logic                        unit_done,
  input  logic [drh_pkg::WORD_W-1:0]  left_hash,
  input  logic [drh_pkg::WORD_W-1:0]  right_hash
);

  localparam logic [drh_pkg::POS_W-1:0] FULL_LEN = drh_pkg::POS_W'(drh_pkg::MAX_LEN);

  drh_pkg::seq_state_t state, state_next;
  logic [drh_pkg::POS_W-1:0]  len_q, len_next;
  logic [drh_pkg::POS_W-1:0]  bpos_q;
  logic [drh_pkg::POS_W-1:0]  epos_q;
  logic [drh_pkg::CHAR_W-1:0] ch_q;
  drh_pkg::status_t           pend_status, pend_status_next;
  logic                       pend_hash, pend_hash_next;
  logic                       accept;
  logic                       load_out;

  assign in_stall = (state != drh_pkg::SQ_IDLE);
  assign accept   = in_valid && !in_stall;
  assign load_out = (state == drh_pkg::SQ_DONE) && (!out_valid || !out_stall);

  // State and control registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= drh_pkg::SQ_IDLE;
      len_q       <= '0;
      pend_status <= drh_pkg::STAT_OK;
      pend_hash   <= 1'b0;
      out_valid   <= 1'b0;
    end else begin
      state       <= state_next;
      len_q       <= len_next;
      pend_status <= pend_status_next;
      pend_hash   <= pend_hash_next;
      out_valid   <= load_out || (out_valid && out_stall);
    end
  end

  // Request payload and result registers.
  always_ff @(posedge clk) begin
    if (accept) begin
      bpos_q <= begin_pos;
      epos_q <= end_pos;
      ch_q   <= char_byte;
    end
    if (load_out) begin
      status      <= pend_status;
      hash_value  <= pend_hash ? {left_hash, 1'b0, right_hash} : '0;
      string_size <= len_q;
    end
  end

  // Next state and lane control.
  always_comb begin
    state_next       = state;
    len_next         = len_q;
    pend_status_next = pend_status;
    pend_hash_next   = pend_hash;
    ctl              = '0;
    ctl.ch           = ch_q;
    ctl.wr_pos       = len_q + 1'b1;
    ctl.src          = drh_pkg::SRC_PFX_BASE;
    unique case (state)
      drh_pkg::SQ_IDLE: begin
        if (accept) begin
          pend_status_next = drh_pkg::STAT_OK;
          pend_hash_next   = 1'b0;
          state_next       = drh_pkg::SQ_DONE;
          unique case (func)
            drh_pkg::FN_APPEND: begin
              if (len_q >= FULL_LEN) begin
                pend_status_next = drh_pkg::STAT_FULL;
              end else begin
                state_next = drh_pkg::SQ_A_RD;
              end
            end
            drh_pkg::FN_QUERY: begin
              if (begin_pos > end_pos || end_pos > len_q) begin
                pend_status_next = drh_pkg::STAT_BAD_RANGE;
              end else begin
                pend_hash_next = 1'b1;
                state_next     = drh_pkg::SQ_Q_RD;
              end
            end
            drh_pkg::FN_CLEAR: begin
              len_next = '0;
            end
            default: ;
          endcase
        end
      end
      drh_pkg::SQ_A_RD: begin
        ctl.rd_pfx  = 1'b1;
        ctl.pfx_pos = len_q;
        ctl.rd_pow  = 1'b1;
        ctl.pow_pos = len_q;
        state_next  = drh_pkg::SQ_A_MUL1;
      end
      drh_pkg::SQ_A_MUL1: begin
        ctl.start  = 1'b1;
        ctl.src    = drh_pkg::SRC_PFX_BASE;
        state_next = drh_pkg::SQ_A_RED1;
      end
      drh_pkg::SQ_A_RED1: begin
        if (unit_done) begin
          ctl.wr_pfx = 1'b1;
          state_next = drh_pkg::SQ_A_MUL2;
        end
      end
      drh_pkg::SQ_A_MUL2: begin
        ctl.start  = 1'b1;
        ctl.src    = drh_pkg::SRC_POW_BASE;
        state_next = drh_pkg::SQ_A_RED2;
      end
      drh_pkg::SQ_A_RED2: begin
        if (unit_done) begin
          ctl.wr_pow = 1'b1;
          len_next   = len_q + 1'b1;
          state_next = drh_pkg::SQ_DONE;
        end
      end
      drh_pkg::SQ_Q_RD: begin
        ctl.rd_pfx  = 1'b1;
        ctl.pfx_pos = bpos_q;
        ctl.rd_pow  = 1'b1;
        ctl.pow_pos = epos_q - bpos_q;
        state_next  = drh_pkg::SQ_Q_MUL;
      end
      drh_pkg::SQ_Q_MUL: begin
        // The product uses the start prefix; the end prefix is fetched meanwhile.
        ctl.start   = 1'b1;
        ctl.src     = drh_pkg::SRC_PFX_POW;
        ctl.rd_pfx  = 1'b1;
        ctl.pfx_pos = epos_q;
        state_next  = drh_pkg::SQ_Q_RED1;
      end
      drh_pkg::SQ_Q_RED1: begin
        if (unit_done) begin
          ctl.take_x = 1'b1;
          state_next = drh_pkg::SQ_Q_LDA;
        end
      end
      drh_pkg::SQ_Q_LDA: begin
        ctl.start  = 1'b1;
        ctl.src    = drh_pkg::SRC_PFX;
        state_next = drh_pkg::SQ_Q_RED2;
      end
      drh_pkg::SQ_Q_RED2: begin
        if (unit_done) begin
          ctl.take_hash = 1'b1;
          state_next    = drh_pkg::SQ_DONE;
        end
      end
      drh_pkg::SQ_DONE: begin
        if (load_out) begin
          state_next = drh_pkg::SQ_IDLE;
        end
      end
      default: state_next = drh_pkg::SQ_IDLE;
    endcase
  end

`ifndef ASSERT_OFF
  a_len_bound: assert property (@(posedge clk) disable iff (rst) len_q <= FULL_LEN)
    else $error("string length beyond store size");
  a_append_grows: assert property (@(posedge clk) disable iff (rst)
    (state == drh_pkg::SQ_A_RED2 && unit_done) |=> len_q == $past(len_q) + 1'b1)
    else $error("append did not extend the string by one");
  a_query_range: assert property (@(posedge clk) disable iff (rst)
    (state == drh_pkg::SQ_Q_RED2 && unit_done) |-> (bpos_q <= epos_q && epos_q <= len_q))
    else $error("hash computed for an out-of-range query");
  a_full_status: assert property (@(posedge clk) disable iff (rst)
    (state == drh_pkg::SQ_DONE && pend_status == drh_pkg::STAT_FULL) |-> len_q == FULL_LEN)
    else $error("store-full status with room left");
`endif

endmodule

// ===== hw/rtl/double_rolling_hash_engine_top.sv =====
// Double polynomial rolling hash engine. Each request carries a func code: append a byte
// (extends both prefix hashes and both power tables), query the substring hash of
// [begin_pos, end_pos), or clear the string. Exactly one result comes back per request,
// with status, the packed hash pair (left hash in bits 62:32, right hash in bits 30:0) and
// the string size after the request. One request is handled at a time. For appends and
// valid queries, every hash lane has one bit-serial restoring reduction unit that retires
// one dividend bit per cycle over a 63-bit dividend, and it runs twice per request; around
// the two passes come the memory read, the two operand setups, the result load and the
// return to idle. Clears, unused func codes, bad ranges and appends to a full store skip
// the reduction unit and go straight to the result load. A finished result sits in an
// output register, so the next request is taken while it waits. Base and modulus
// registers are to be written through the cfg port only while the engine is idle; the
// block itself does not enforce this. A modulus of zero behaves as one.
module double_rolling_hash_engine_top (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        cfg_wr_en,
  input  logic [1:0]                  cfg_index,
  input  logic [drh_pkg::WORD_W-1:0]  cfg_data,
  input  logic                        in_valid,
  output logic                        in_stall,
  input  logic [1:0]                  func,
  input  logic [drh_pkg::CHAR_W-1:0]  char_byte,
  input  logic [drh_pkg::POS_W-1:0]   begin_pos,
  input  logic [drh_pkg::POS_W-1:0]   end_pos,
  output logic                        out_valid,
  input  logic                        out_stall,
  output logic [1:0]                  status,
  output logic [drh_pkg::HASH_W-1:0]  hash_value,
  output logic [drh_pkg::POS_W-1:0]   string_size
);

  logic [drh_pkg::WORD_W-1:0] base_left;
  logic [drh_pkg::WORD_W-1:0] base_right;
  logic [drh_pkg::WORD_W-1:0] modulus_left;
  logic [drh_pkg::WORD_W-1:0] modulus_right;
  drh_pkg::lane_ctl_t         ctl;
  logic                       left_done;
  logic                       right_done;
  logic [drh_pkg::WORD_W-1:0] left_hash;
  logic [drh_pkg::WORD_W-1:0] right_hash;

  // Configuration registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      base_left     <= drh_pkg::BASE_LEFT_RST;
      base_right    <= drh_pkg::BASE_RIGHT_RST;
      modulus_left  <= drh_pkg::MODULUS_LEFT_RST;
      modulus_right <= drh_pkg::MODULUS_RIGHT_RST;
    end else if (cfg_wr_en) begin
      unique case (cfg_index)
        drh_pkg::REG_BASE_LEFT:     base_left     <= cfg_data;
        drh_pkg::REG_BASE_RIGHT:    base_right    <= cfg_data;
        drh_pkg::REG_MODULUS_LEFT:  modulus_left  <= cfg_data;
        drh_pkg::REG_MODULUS_RIGHT: modulus_right <= cfg_data;
        default: ;
      endcase
    end
  end

  drh_seq u_seq (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (in_valid),
    .in_stall   (in_stall),
    .func       (func),
    .char_byte  (char_byte),
    .begin_pos  (begin_pos),
    .end_pos    (end_pos),
    .out_valid  (out_valid),
    .out_stall  (out_stall),
    .status     (status),
    .hash_value (hash_value),
    .string_size(string_size),
    .ctl        (ctl),
    .unit_done  (left_done & right_done),
    .left_hash  (left_hash),
    .right_hash (right_hash)
  );

  drh_lane u_left (
    .clk    (clk),
    .rst    (rst),
    .ctl    (ctl),
    .base   (base_left),
    .modulus(modulus_left),
    .done   (left_done),
    .hash   (left_hash)
  );

  drh_lane u_right (
    .clk    (clk),
    .rst    (rst),
    .ctl    (ctl),
    .base   (base_right),
    .modulus(modulus_right),
    .done   (right_done),
    .hash   (right_hash)
  );

`ifndef ASSERT_OFF
  a_lanes_lockstep: assert property (@(posedge clk) disable iff (rst) left_done == right_done)
    else $error("hash lanes finished in different cycles");
`endif

endmodule

// ===== tb/sv/tb.sv =====
module tb;

  localparam logic [1:0] FN_UNUSED = 2'd3;
  localparam int POS_MAX = (1 << drh_pkg::POS_W) - 1;
  localparam int HALF_SHIFT = 32;
  localparam longint unsigned LOW_WORD = 64'hffff_ffff;
  localparam logic [drh_pkg::WORD_W-1:0] WORD_MAX = {drh_pkg::WORD_W{1'b1}};
  localparam int RAND_PER_SETTING = 267;
  localparam int WATCHDOG_LIMIT = 4000;
  localparam int SETTLE_CYCLES = 4;
  localparam int TAIL_CYCLES = 150;
  localparam int REPORT_LIMIT = 10;

  // One expected result of the engine.
  typedef struct {
    logic [1:0]                 st;
    logic [drh_pkg::HASH_W-1:0] hash;
    logic [drh_pkg::POS_W-1:0]  held;
  } hash_result_t;

  // Tracks the string and its prefix and power tables, predicts every result and
  // compares what the engine returns against the oldest prediction.
  class hash_scoreboard;
    logic [drh_pkg::WORD_W-1:0] base_l, base_r, mod_l, mod_r;
    logic [drh_pkg::WORD_W-1:0] pfx_l [0:drh_pkg::MAX_LEN];
    logic [drh_pkg::WORD_W-1:0] pfx_r [0:drh_pkg::MAX_LEN];
    logic [drh_pkg::WORD_W-1:0] pow_l [0:drh_pkg::MAX_LEN];
    logic [drh_pkg::WORD_W-1:0] pow_r [0:drh_pkg::MAX_LEN];
    int unsigned held;
    hash_result_t expected_results [$];
    int mismatches;
    int n_checked, n_append, n_full, n_query, n_bad, n_clear, n_unused, n_settings;

    function new();
      base_l = drh_pkg::BASE_LEFT_RST;
      base_r = drh_pkg::BASE_RIGHT_RST;
      mod_l = drh_pkg::MODULUS_LEFT_RST;
      mod_r = drh_pkg::MODULUS_RIGHT_RST;
      for (int i = 0; i <= drh_pkg::MAX_LEN; i++) begin
        pfx_l[i] = '0;
        pfx_r[i] = '0;
        pow_l[i] = '0;
        pow_r[i] = '0;
      end
      pow_l[0] = 1;
      pow_r[0] = 1;
      held = 0;
      mismatches = 0;
      n_checked = 0;
      n_append = 0;
      n_full = 0;
      n_query = 0;
      n_bad = 0;
      n_clear = 0;
      n_unused = 0;
      n_settings = 1;
    endfunction

    function void set_reg(drh_pkg::cfg_reg_t idx, logic [drh_pkg::WORD_W-1:0] val);
      case (idx)
        drh_pkg::REG_BASE_LEFT:     base_l = val;
        drh_pkg::REG_BASE_RIGHT:    base_r = val;
        drh_pkg::REG_MODULUS_LEFT:  mod_l = val;
        drh_pkg::REG_MODULUS_RIGHT: mod_r = val;
        default: ;
      endcase
    endfunction

    function int unsigned held_bytes();
      return held;
    endfunction

    function int pending();
      return expected_results.size();
    endfunction

    // Hash of a window: (h_end - h_begin * p_len) mod m with operands reduced first.
    function longint unsigned window_hash(longint unsigned a, longint unsigned b,
                                          longint unsigned p, longint unsigned m);
      longint unsigned x;
      x = ((b % m) * (p % m)) % m;
      return ((a % m) + m - x) % m;
    endfunction

    // Applies one request to the tracked string and returns the result it causes.
    function hash_result_t compute_result(logic [1:0] f, logic [drh_pkg::CHAR_W-1:0] c,
                                          logic [drh_pkg::POS_W-1:0] b,
                                          logic [drh_pkg::POS_W-1:0] e);
      hash_result_t r;
      longint unsigned ml, mr, bl, br, lh, rh, len;
      ml = (mod_l == 0) ? 1 : mod_l;
      mr = (mod_r == 0) ? 1 : mod_r;
      r.st = drh_pkg::STAT_OK;
      r.hash = '0;
      case (f)
        drh_pkg::FN_APPEND: begin
          if (held >= drh_pkg::MAX_LEN) begin
            r.st = drh_pkg::STAT_FULL;
            n_full++;
          end else begin
            bl = base_l % ml;
            br = base_r % mr;
            lh = pfx_l[held];
            rh = pfx_r[held];
            pfx_l[held + 1] = drh_pkg::WORD_W'(((lh % ml) * bl + c) % ml);
            pfx_r[held + 1] = drh_pkg::WORD_W'(((rh % mr) * br + c) % mr);
            lh = pow_l[held];
            rh = pow_r[held];
            pow_l[held + 1] = drh_pkg::WORD_W'(((lh % ml) * bl) % ml);
            pow_r[held + 1] = drh_pkg::WORD_W'(((rh % mr) * br) % mr);
            held++;
            n_append++;
          end
        end
        drh_pkg::FN_QUERY: begin
          if (b > e || e > held) begin
            r.st = drh_pkg::STAT_BAD_RANGE;
            n_bad++;
          end else begin
            len = e - b;
            lh = window_hash(pfx_l[e], pfx_l[b], pow_l[len], ml);
            rh = window_hash(pfx_r[e], pfx_r[b], pow_r[len], mr);
            r.hash = drh_pkg::HASH_W'((lh << HALF_SHIFT) | (rh & LOW_WORD));
            n_query++;
          end
        end
        drh_pkg::FN_CLEAR: begin
          held = 0;
          n_clear++;
        end
        default: n_unused++;
      endcase
      r.held = drh_pkg::POS_W'(held);
      return r;
    endfunction

    function void note_request(logic [1:0] f, logic [drh_pkg::CHAR_W-1:0] c,
                               logic [drh_pkg::POS_W-1:0] b, logic [drh_pkg::POS_W-1:0] e);
      expected_results.insert(expected_results.size(), compute_result(f, c, b, e));
    endfunction

    function void check_result(logic [1:0] st, logic [drh_pkg::HASH_W-1:0] hash,
                               logic [drh_pkg::POS_W-1:0] sz);
      hash_result_t exp;
      if (expected_results.size() == 0) begin
        mismatches++;
        if (mismatches <= REPORT_LIMIT)
          $display("unexpected result: status %0d hash %h size %0d", st, hash, sz);
        return;
      end
      exp = expected_results.pop_front();
      n_checked++;
      if (st !== exp.st || hash !== exp.hash || sz !== exp.held) begin
        mismatches++;
        if (mismatches <= REPORT_LIMIT)
          $display("result %0d: status %0d/%0d hash %h/%h size %0d/%0d (expected/actual)",
                   n_checked, exp.st, st, exp.hash, hash, exp.held, sz);
      end
    endfunction
  endclass

  logic                         clk = 1'b0;
  logic                         rst;
  logic                         cfg_wr_en;
  logic [1:0]                   cfg_index;
  logic [drh_pkg::WORD_W-1:0]   cfg_data;
  logic                         in_valid;
  logic                         in_stall;
  logic [1:0]                   func;
  logic [drh_pkg::CHAR_W-1:0]   char_byte;
  logic [drh_pkg::POS_W-1:0]    begin_pos;
  logic [drh_pkg::POS_W-1:0]    end_pos;
  logic                         out_valid;
  logic                         out_stall;
  logic [1:0]                   status;
  logic [drh_pkg::HASH_W-1:0]   hash_value;
  logic [drh_pkg::POS_W-1:0]    string_size;

  int send_idle_pct;
  int recv_idle_pct;
  hash_scoreboard sb;

  double_rolling_hash_engine_top u_top (
    .clk         (clk),
    .rst         (rst),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_index   (cfg_index),
    .cfg_data    (cfg_data),
    .in_valid    (in_valid),
    .in_stall    (in_stall),
    .func        (func),
    .char_byte   (char_byte),
    .begin_pos   (begin_pos),
    .end_pos     (end_pos),
    .out_valid   (out_valid),
    .out_stall   (out_stall),
    .status      (status),
    .hash_value  (hash_value),
    .string_size (string_size)
  );

  always #2 clk = ~clk;

  // The receiver stalls at random on each falling edge.
  always @(negedge clk) begin
    out_stall <= ($urandom_range(0, 99) < recv_idle_pct);
  end

  // Every result that the engine hands over is checked.
  always @(posedge clk) begin
    if (!rst && out_valid && !out_stall) begin
      sb.check_result(status, hash_value, string_size);
    end
  end

  // Ends the run when nothing moves on either channel for too long.
  initial begin : watchdog
    int quiet;
    quiet = 0;
    while (quiet < WATCHDOG_LIMIT) begin
      @(posedge clk);
      if ((in_valid && !in_stall) || (out_valid && !out_stall)) quiet = 0;
      else quiet++;
    end
    $display("timeout: no handshake for %0d cycles", WATCHDOG_LIMIT);
    $display("SCOREBOARD MISMATCH");
    $finish;
  end

  // Presents one request, holds it until accepted and notes it.
  task automatic send_req(logic [1:0] f, logic [drh_pkg::CHAR_W-1:0] c,
                          logic [drh_pkg::POS_W-1:0] b, logic [drh_pkg::POS_W-1:0] e);
    @(negedge clk);
    while ($urandom_range(0, 99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid <= 1'b1;
    func <= f;
    char_byte <= c;
    begin_pos <= b;
    end_pos <= e;
    do @(posedge clk); while (in_stall);
    sb.note_request(f, c, b, e);
  endtask

  // Drops valid and waits until every expected result has come back.
  task automatic drain();
    @(negedge clk);
    in_valid <= 1'b0;
    while (sb.pending() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(negedge clk);
  endtask

  task automatic write_reg(drh_pkg::cfg_reg_t idx, logic [drh_pkg::WORD_W-1:0] val);
    @(negedge clk);
    cfg_wr_en <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    @(negedge clk);
    cfg_wr_en <= 1'b0;
    sb.set_reg(idx, val);
  endtask

  // New settings are loaded only once the engine has gone idle.
  task automatic load_settings(logic [drh_pkg::WORD_W-1:0] bl, logic [drh_pkg::WORD_W-1:0] br,
                               logic [drh_pkg::WORD_W-1:0] ml, logic [drh_pkg::WORD_W-1:0] mr);
    drain();
    write_reg(drh_pkg::REG_BASE_LEFT, bl);
    write_reg(drh_pkg::REG_BASE_RIGHT, br);
    write_reg(drh_pkg::REG_MODULUS_LEFT, ml);
    write_reg(drh_pkg::REG_MODULUS_RIGHT, mr);
    sb.n_settings++;
  endtask

  // Mostly appends and in-range queries, with some bad ranges, clears and unused codes.
  task automatic send_random_req();
    int unsigned pick, held, lo, hi;
    logic [drh_pkg::CHAR_W-1:0] c;
    logic [drh_pkg::POS_W-1:0] b, e;
    pick = $urandom_range(0, 99);
    held = sb.held_bytes();
    c = drh_pkg::CHAR_W'($urandom);
    b = drh_pkg::POS_W'($urandom);
    e = drh_pkg::POS_W'($urandom);
    if (pick < 50) begin
      send_req(drh_pkg::FN_APPEND, c, b, e);
    end else if (pick < 78) begin
      hi = $urandom_range(0, held);
      lo = $urandom_range(0, hi);
      send_req(drh_pkg::FN_QUERY, c, drh_pkg::POS_W'(lo), drh_pkg::POS_W'(hi));
    end else if (pick < 84) begin
      hi = $urandom_range(held + 1, POS_MAX);
      send_req(drh_pkg::FN_QUERY, c, b, drh_pkg::POS_W'(hi));
    end else if (pick < 90) begin
      hi = $urandom_range(0, POS_MAX - 1);
      lo = $urandom_range(hi + 1, POS_MAX);
      send_req(drh_pkg::FN_QUERY, c, drh_pkg::POS_W'(lo), drh_pkg::POS_W'(hi));
    end else if (pick < 93) begin
      send_req(drh_pkg::FN_CLEAR, c, b, e);
    end else if (pick < 96) begin
      send_req(FN_UNUSED, c, b, e);
    end else begin
      send_req(drh_pkg::FN_APPEND, pick[0] ? 8'hff : 8'h00, b, e);
    end
  endtask

  task automatic random_phase();
    for (int i = 0; i < RAND_PER_SETTING; i++) send_random_req();
  endtask

  initial begin
    sb = new();
    rst = 1'b1;
    cfg_wr_en = 1'b0;
    cfg_index = drh_pkg::REG_BASE_LEFT;
    cfg_data = '0;
    in_valid = 1'b0;
    func = drh_pkg::FN_CLEAR;
    char_byte = '0;
    begin_pos = '0;
    end_pos = '0;
    out_stall = 1'b0;
    send_idle_pct = 7;
    recv_idle_pct = 65;
    repeat (10) @(negedge clk);
    rst <= 1'b0;

    // Directed requests under the reset settings.
    send_req(drh_pkg::FN_QUERY, 8'h00, drh_pkg::POS_W'(0), drh_pkg::POS_W'(0));
    send_req(drh_pkg::FN_QUERY, 8'h00, drh_pkg::POS_W'(0), drh_pkg::POS_W'(1));
    send_req(drh_pkg::FN_APPEND, 8'h00, '0, '0);
    send_req(drh_pkg::FN_APPEND, 8'hff, '0, '0);
    send_req(drh_pkg::FN_APPEND, 8'h5a, '0, '0);
    send_req(drh_pkg::FN_APPEND, 8'ha5, '0, '0);
    send_req(drh_pkg::FN_QUERY, 8'h00, drh_pkg::POS_W'(0), drh_pkg::POS_W'(4));
    send_req(drh_pkg::FN_QUERY, 8'h00, drh_pkg::POS_W'(1), drh_pkg::POS_W'(3));
    send_req(drh_pkg::FN_QUERY, 8'h00, drh_pkg::POS_W'(4), drh_pkg::POS_W'(4));
    send_req(drh_pkg::FN_QUERY, 8'h00, drh_pkg::POS_W'(3), drh_pkg::POS_W'(2));
    send_req(drh_pkg::FN_QUERY, 8'hff, '1, '1);
    send_req(drh_pkg::FN_QUERY, 8'h00, drh_pkg::POS_W'(0), '1);
    send_req(FN_UNUSED, 8'hff, '1, '1);
    send_req(drh_pkg::FN_CLEAR, 8'hff, '1, '1);
    send_req(drh_pkg::FN_QUERY, 8'h00, drh_pkg::POS_W'(0), drh_pkg::POS_W'(0));
    send_req(drh_pkg::FN_QUERY, 8'h00, drh_pkg::POS_W'(0), drh_pkg::POS_W'(4));
    send_req(drh_pkg::FN_APPEND, 8'h80, '0, '0);
    send_req(drh_pkg::FN_QUERY, 8'h00, drh_pkg::POS_W'(0), drh_pkg::POS_W'(1));
    send_req(drh_pkg::FN_APPEND, 8'h01, '1, '1);
    send_req(drh_pkg::FN_QUERY, 8'h00, drh_pkg::POS_W'(1), drh_pkg::POS_W'(2));
    send_req(drh_pkg::FN_QUERY, 8'h00, drh_pkg::POS_W'(0), drh_pkg::POS_W'(2));

    // Sender mostly busy, receiver stalling often.
    load_settings(WORD_MAX, '0, WORD_MAX, drh_pkg::WORD_W'(2));
    random_phase();
    load_settings(drh_pkg::WORD_W'($urandom), drh_pkg::WORD_W'($urandom),
                  drh_pkg::WORD_W'(1), drh_pkg::WORD_W'($urandom_range(2, WORD_MAX)));
    random_phase();

    // Sender idling often, receiver mostly ready; a zero modulus on the left.
    send_idle_pct = 65;
    recv_idle_pct = 7;
    load_settings('0, WORD_MAX, '0, WORD_MAX);
    random_phase();
    load_settings(drh_pkg::WORD_W'($urandom), drh_pkg::WORD_W'($urandom),
                  drh_pkg::MODULUS_LEFT_RST, drh_pkg::MODULUS_RIGHT_RST);
    random_phase();

    // Full rate on both sides.
    send_idle_pct = 0;
    recv_idle_pct = 0;
    load_settings(drh_pkg::WORD_W'($urandom), drh_pkg::WORD_W'($urandom),
                  drh_pkg::WORD_W'($urandom), drh_pkg::WORD_W'($urandom));
    random_phase();
    load_settings(drh_pkg::WORD_W'($urandom), drh_pkg::WORD_W'($urandom),
                  drh_pkg::WORD_W'($urandom_range(2, WORD_MAX)),
                  drh_pkg::WORD_W'($urandom_range(2, WORD_MAX)));
    random_phase();

    drain();
    repeat (TAIL_CYCLES) @(posedge clk);
    $display("checked %0d results over %0d register settings under three stall patterns",
             sb.n_checked, sb.n_settings);
    $display("appends %0d (full %0d), queries %0d (bad range %0d), clears %0d, unused %0d",
             sb.n_append, sb.n_full, sb.n_query, sb.n_bad, sb.n_clear, sb.n_unused);
    if (sb.mismatches == 0 && sb.pending() == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("%0d mismatches, %0d results missing", sb.mismatches, sb.pending());
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule

// ===== sim.f =====
hw/rtl/drh_pkg.sv
hw/rtl/drh_ram.sv
hw/rtl/drh_mod_unit.sv
hw/rtl/drh_lane.sv
hw/rtl/drh_seq.sv
hw/rtl/double_rolling_hash_engine_top.sv
tb/sv/tb.sv
